FILE: hdl/pca_sma_pkg.sv
package pca_sma_pkg;

	localparam int FEATURES_DEFAULT = 4;
	localparam int SAMPLE_FIELDS    = 4;

	localparam int SAMPLE_W = 16;
	localparam int DIFF_W   = 17;
	localparam int SCALE_W  = 24;
	localparam int ENTRY_W  = 64;
	// Operand width of the shared multiplier: a scaled Q.16 value reaches 2^32.
	localparam int OPND_W   = 33;
	localparam int PROD_W   = 2 * OPND_W;

	localparam logic signed [ENTRY_W-1:0] ENTRY_MAX = {1'b0, {(ENTRY_W-1){1'b1}}};
	localparam logic signed [ENTRY_W-1:0] ENTRY_MIN = {1'b1, {(ENTRY_W-1){1'b0}}};
	localparam logic signed [ENTRY_W-1:0] ONE_Q32   = 64'sh0000_0001_0000_0000;

	typedef enum logic [1:0] {
		OP_CLEAR = 2'd0,
		OP_LOAD  = 2'd1,
		OP_ACC   = 2'd2,
		OP_READ  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		METHOD_CORR   = 2'd0,
		METHOD_COV    = 2'd1,
		METHOD_SSCP   = 2'd2,
		METHOD_UNUSED = 2'd3
	} method_t;

	// Position of entry (r, c) in the row-major upper triangle, diagonal included.
	function automatic int tri_index(input int r, input int c, input int f);
		int lo;
		int hi;
		lo = (r < c) ? r : c;
		hi = (r < c) ? c : r;
		return lo * f - ((lo * (lo - 1)) >>> 1) + (hi - lo);
	endfunction

	function automatic logic signed [ENTRY_W-1:0] sat_prod(input logic signed [PROD_W-1:0] p);
		logic [PROD_W-ENTRY_W:0] top;
		top = p[PROD_W-1:ENTRY_W-1];
		if (top == '0 || top == '1) begin
			return p[ENTRY_W-1:0];
		end
		return p[PROD_W-1] ? ENTRY_MIN : ENTRY_MAX;
	endfunction

	function automatic logic signed [ENTRY_W-1:0] sat_add(input logic signed [ENTRY_W-1:0] a,
			input logic signed [ENTRY_W-1:0] b);
		logic signed [ENTRY_W:0] s;
		s = {a[ENTRY_W-1], a} + {b[ENTRY_W-1], b};
		if (s[ENTRY_W] != s[ENTRY_W-1]) begin
			return s[ENTRY_W] ? ENTRY_MIN : ENTRY_MAX;
		end
		return s[ENTRY_W-1:0];
	endfunction

endpackage

FILE: hdl/pca_sma_if.sv
interface pca_sma_cmd_if;
	logic                                    valid;
	logic                                    ready;
	logic [1:0]                              operation;
	logic signed [pca_sma_pkg::SAMPLE_W-1:0] sample_0;
	logic signed [pca_sma_pkg::SAMPLE_W-1:0] sample_1;
	logic signed [pca_sma_pkg::SAMPLE_W-1:0] sample_2;
	logic signed [pca_sma_pkg::SAMPLE_W-1:0] sample_3;
	logic                                    cell_missing;
	logic [1:0]                              stat_feature;
	logic signed [pca_sma_pkg::SAMPLE_W-1:0] stat_mean;
	logic [pca_sma_pkg::SCALE_W-1:0]         stat_inv_scale;
	logic [1:0]                              read_row;
	logic [1:0]                              read_col;

	modport source (
		output valid, operation, sample_0, sample_1, sample_2, sample_3, cell_missing,
			stat_feature, stat_mean, stat_inv_scale, read_row, read_col,
		input  ready
	);
	modport sink (
		input  valid, operation, sample_0, sample_1, sample_2, sample_3, cell_missing,
			stat_feature, stat_mean, stat_inv_scale, read_row, read_col,
		output ready
	);
endinterface

interface pca_sma_rsp_if;
	logic                                   valid;
	logic                                   ready;
	logic signed [pca_sma_pkg::ENTRY_W-1:0] entry_value;

	modport source (output valid, entry_value, input ready);
	modport sink (input valid, entry_value, output ready);
endinterface

FILE: hdl/pca_sma_ram.sv
module pca_sma_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 10
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: hdl/pca_scatter_matrix_accumulator_top.sv
// Scatter-matrix accumulator: builds the upper triangle of a FEATURES x FEATURES
// correlation, covariance or SSCP matrix in a one-read, one-write RAM of 64-bit
// saturating accumulators, one cell per accumulate transfer. Clear and load
// transfers act as they are accepted; a read passes through S_READ and waits there
// only while the output register is still full. An accumulate passes through S_SCALE,
// S_MAC and S_DRAIN, paced by the single shared multiplier, which first scales one
// feature per cycle and then forms one pair product per cycle, each read-modified-written
// through the accumulator RAM. A cell marked missing is accepted and changes nothing.
// The method register may only be written while the block is idle.
module pca_scatter_matrix_accumulator_top #(
	parameter int FEATURES = pca_sma_pkg::FEATURES_DEFAULT
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_wdata,
	pca_sma_cmd_if.sink          cmd,
	pca_sma_rsp_if.source        rsp
);

	localparam int PAIRS = FEATURES * (FEATURES + 1) / 2;
	localparam int FW    = $clog2(FEATURES);
	localparam int AW    = $clog2(PAIRS);
	localparam int VW    = pca_sma_pkg::OPND_W;
	localparam int EW    = pca_sma_pkg::ENTRY_W;
	localparam int SW    = pca_sma_pkg::SAMPLE_W;
	localparam int DW    = pca_sma_pkg::DIFF_W;
	localparam int CW    = pca_sma_pkg::SCALE_W;
	localparam int PW    = pca_sma_pkg::PROD_W;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCALE,
		S_MAC,
		S_DRAIN,
		S_READ
	} state_t;

	state_t                 state_q;
	logic [1:0]             method_q;
	logic [FW-1:0]          r_q;
	logic [FW-1:0]          c_q;
	logic [AW-1:0]          addr_q;
	logic [PAIRS-1:0]       valid_q;
	logic                   out_valid_q;
	logic signed [EW-1:0]   entry_value_q;
	logic                   rd_zero_q;
	logic                   rd_one_q;
	logic [AW-1:0]          rd_addr_q;

	logic signed [SW-1:0]   mean_q   [FEATURES];
	logic [CW-1:0]          scale_q  [FEATURES];
	logic signed [SW-1:0]   sample_q [FEATURES];
	logic signed [VW-1:0]   v_q      [FEATURES];
	logic signed [VW-1:0]   v_r_q;

	logic                   scale_s1;
	logic                   wr_s1;
	logic [FW-1:0]          idx_s1;
	logic [AW-1:0]          addr_s1;
	logic signed [PW-1:0]   prod_s1;

	logic signed [SW-1:0]   smp     [pca_sma_pkg::SAMPLE_FIELDS];
	logic signed [SW-1:0]   smp_ext [FEATURES];

	logic                   accept;
	logic                   corr;
	logic                   take_acc;
	logic                   take_read;
	logic                   rd_in_range;
	logic [AW-1:0]          rd_addr;
	logic                   c_last;
	logic                   r_last;
	logic                   diag;
	logic signed [DW-1:0]   diff;
	logic signed [VW-1:0]   vc;
	logic signed [VW-1:0]   mul_a;
	logic signed [VW-1:0]   mul_b;
	logic signed [PW-1:0]   prod;
	logic                   ram_re;
	logic [AW-1:0]          ram_raddr;
	logic [EW-1:0]          ram_rdata;
	logic signed [EW-1:0]   acc_old;
	logic signed [EW-1:0]   acc_new;
	logic signed [EW-1:0]   rd_value;
	logic                   out_free;

	assign accept    = cmd.valid && cmd.ready;
	assign corr      = method_q != pca_sma_pkg::METHOD_COV && method_q != pca_sma_pkg::METHOD_SSCP;
	assign take_acc  = accept && cmd.operation == pca_sma_pkg::OP_ACC && !cmd.cell_missing;
	assign take_read = accept && cmd.operation == pca_sma_pkg::OP_READ;
	assign cmd.ready = state_q == S_IDLE;

	assign rd_in_range = int'(cmd.read_row) < FEATURES && int'(cmd.read_col) < FEATURES;
	assign rd_addr     = rd_in_range ?
		AW'(pca_sma_pkg::tri_index(int'(cmd.read_row), int'(cmd.read_col), FEATURES)) : '0;

	assign smp[0] = cmd.sample_0;
	assign smp[1] = cmd.sample_1;
	assign smp[2] = cmd.sample_2;
	assign smp[3] = cmd.sample_3;

	for (genvar g = 0; g < FEATURES; g++) begin : g_smp
		if (g < pca_sma_pkg::SAMPLE_FIELDS) begin : g_field
			assign smp_ext[g] = smp[g];
		end else begin : g_zero
			assign smp_ext[g] = '0;
		end
	end

	assign c_last = c_q == FW'(FEATURES - 1);
	assign r_last = r_q == FW'(FEATURES - 1);
	assign diag   = r_q == c_q;

	// Shared multiplier: scaling of one feature per cycle, then one pair product.
	assign diff = DW'(sample_q[c_q]) - DW'(mean_q[c_q]);
	assign vc   = v_q[c_q];

	always_comb begin
		if (state_q == S_MAC) begin
			mul_a = diag ? vc : v_r_q;
			mul_b = vc;
		end else begin
			mul_a = (method_q == pca_sma_pkg::METHOD_SSCP) ? VW'(sample_q[c_q]) : VW'(diff);
			mul_b = corr ? VW'({1'b0, scale_q[c_q]}) : VW'(1);
		end
	end

	assign prod = mul_a * mul_b;

	assign ram_re    = take_read || state_q == S_MAC;
	assign ram_raddr = (state_q == S_MAC) ? addr_q : rd_addr;

	assign acc_old  = valid_q[addr_s1] ? ram_rdata : '0;
	assign acc_new  = pca_sma_pkg::sat_add(acc_old, pca_sma_pkg::sat_prod(prod_s1));
	assign rd_value = rd_zero_q ? '0 :
		rd_one_q ? pca_sma_pkg::ONE_Q32 :
		valid_q[rd_addr_q] ? ram_rdata : '0;
	assign out_free = !out_valid_q || rsp.ready;

	pca_sma_ram #(
		.WIDTH (EW),
		.DEPTH (PAIRS)
	) u_acc_ram (
		.clk   (clk),
		.we    (wr_s1),
		.waddr (addr_s1),
		.wdata (acc_new),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			method_q      <= pca_sma_pkg::METHOD_COV;
			r_q           <= '0;
			c_q           <= '0;
			addr_q        <= '0;
			valid_q       <= '0;
			out_valid_q   <= 1'b0;
			entry_value_q <= '0;
			scale_s1      <= 1'b0;
			wr_s1         <= 1'b0;
		end else begin
			if (cfg_we) begin
				method_q <= cfg_wdata;
			end
			// A read that is finishing refills the result register itself.
			if (out_valid_q && rsp.ready && state_q != S_READ) begin
				out_valid_q <= 1'b0;
			end
			scale_s1 <= state_q == S_SCALE;
			wr_s1    <= state_q == S_MAC && !(corr && diag);
			if (wr_s1) begin
				valid_q[addr_s1] <= 1'b1;
			end
			case (state_q)
				S_IDLE: begin
					if (accept && cmd.operation == pca_sma_pkg::OP_CLEAR) begin
						valid_q <= '0;
					end
					if (take_acc) begin
						c_q     <= '0;
						state_q <= S_SCALE;
					end
					if (take_read) begin
						state_q <= S_READ;
					end
				end
				S_SCALE: begin
					if (c_last) begin
						r_q     <= '0;
						c_q     <= '0;
						addr_q  <= '0;
						state_q <= S_MAC;
					end else begin
						c_q <= c_q + 1'b1;
					end
				end
				S_MAC: begin
					addr_q <= addr_q + 1'b1;
					if (c_last) begin
						if (r_last) begin
							state_q <= S_DRAIN;
						end else begin
							r_q <= r_q + 1'b1;
							c_q <= r_q + 1'b1;
						end
					end else begin
						c_q <= c_q + 1'b1;
					end
				end
				S_DRAIN: begin
					state_q <= S_IDLE;
				end
				S_READ: begin
					// The RAM holds its read data until the result register frees up.
					if (out_free) begin
						out_valid_q   <= 1'b1;
						entry_value_q <= rd_value;
						state_q       <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int f = 0; f < FEATURES; f++) begin
				mean_q[f]  <= '0;
				scale_q[f] <= '0;
			end
		end else if (accept && cmd.operation == pca_sma_pkg::OP_LOAD
				&& int'(cmd.stat_feature) < FEATURES) begin
			mean_q[FW'(cmd.stat_feature)]  <= cmd.stat_mean;
			scale_q[FW'(cmd.stat_feature)] <= cmd.stat_inv_scale;
		end
	end

	always_ff @(posedge clk) begin
		if (take_acc) begin
			sample_q <= smp_ext;
		end
		if (take_read) begin
			rd_zero_q <= !rd_in_range;
			rd_one_q  <= corr && cmd.read_row == cmd.read_col;
			rd_addr_q <= rd_addr;
		end
		if (state_q == S_MAC && diag) begin
			v_r_q <= vc;
		end
		prod_s1 <= prod;
		idx_s1  <= c_q;
		addr_s1 <= addr_q;
		// Correlation keeps floor(d * inv_scale / 256); the other methods keep d or s.
		if (scale_s1) begin
			v_q[idx_s1] <= corr ? prod_s1[VW+7:8] : prod_s1[VW-1:0];
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.entry_value = entry_value_q;

endmodule

FILE: hdl/pca_sma_chk.sv
module pca_sma_chk #(
	parameter int FEATURES = pca_sma_pkg::FEATURES_DEFAULT
) (
	input logic                                   clk,
	input logic                                   arst_n,
	input logic                                   cfg_we,
	input logic [1:0]                             cfg_wdata,
	input logic                                   cmd_valid,
	input logic                                   cmd_ready,
	input logic [1:0]                             cmd_operation,
	input logic                                   cmd_cell_missing,
	input logic [1:0]                             cmd_read_row,
	input logic [1:0]                             cmd_read_col,
	input logic                                   rsp_valid,
	input logic                                   rsp_ready,
	input logic signed [pca_sma_pkg::ENTRY_W-1:0] rsp_entry_value
);

	logic [1:0] method_q;
	logic       cmd_xfer;
	logic       corr_diag_read;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			method_q <= pca_sma_pkg::METHOD_COV;
		end else if (cfg_we) begin
			method_q <= cfg_wdata;
		end
	end

	assign cmd_xfer       = cmd_valid && cmd_ready;
	assign corr_diag_read = cmd_xfer && cmd_operation == pca_sma_pkg::OP_READ
		&& cmd_read_row == cmd_read_col && int'(cmd_read_row) < FEATURES
		&& method_q != pca_sma_pkg::METHOD_COV && method_q != pca_sma_pkg::METHOD_SSCP;

	// A stalled result holds its value.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_entry_value))
		else $error("result changed while stalled");

	// Only a read transfer produces a result.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_xfer && cmd_operation != pca_sma_pkg::OP_READ && !rsp_valid |=> !rsp_valid)
		else $error("result without a read");

	// A cell that is not missing keeps the block busy while it is accumulated.
	a_acc_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_xfer && cmd_operation == pca_sma_pkg::OP_ACC && !cmd_cell_missing |=> !cmd_ready)
		else $error("new transfer taken during accumulation");

	// A correlation diagonal read into an empty output reads as one in Q.32, via S_READ and the result register.
	a_corr_diag: assert property (@(posedge clk) disable iff (!arst_n)
		corr_diag_read && !rsp_valid |=> ##1
			(rsp_valid && rsp_entry_value == pca_sma_pkg::ONE_Q32))
		else $error("correlation diagonal not one");

endmodule

bind pca_scatter_matrix_accumulator_top pca_sma_chk #(
	.FEATURES (FEATURES)
) u_pca_sma_chk (
	.clk              (clk),
	.arst_n           (arst_n),
	.cfg_we           (cfg_we),
	.cfg_wdata        (cfg_wdata),
	.cmd_valid        (cmd.valid),
	.cmd_ready        (cmd.ready),
	.cmd_operation    (cmd.operation),
	.cmd_cell_missing (cmd.cell_missing),
	.cmd_read_row     (cmd.read_row),
	.cmd_read_col     (cmd.read_col),
	.rsp_valid        (rsp.valid),
	.rsp_ready        (rsp.ready),
	.rsp_entry_value  (rsp.entry_value)
);
